/* design/tspr_pkg.sv */
// shared constants and types for the subdiagonal phase removal block
package tspr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int W          = DATA_WIDTH;
  localparam int SQ_W       = 2 * W;
  localparam int NUM_W      = 2 * W + 1;
  localparam int SUM_W      = 2 * W + 2;
  localparam int CNT_W      = $clog2(W + 1);
  localparam int STEP_W     = 3;
  localparam int IN_TDATA_W  = ((2 * W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * W + 7) / 8) * 8;

  localparam logic signed [W-1:0] PH_ONE = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] PH_MIN = {1'b1, {(W-1){1'b0}}};

  // multiply-accumulate steps
  localparam logic [STEP_W-1:0] STEP_RE_SQ = 3'd0;
  localparam logic [STEP_W-1:0] STEP_IM_SQ = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RR    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_II    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RI    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_IR    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_END   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROOT,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_DONE
  } tspr_state_e;

  // handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* design/tspr_sqrt.sv */
// iterative rounded square root, two radicand bits per cycle
module tspr_sqrt
  import tspr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] rad_i,
  output unit_stat_t      stat_o,
  output logic [W-1:0]    root_o
);

  localparam int RW = W + 4;

  logic [SQ_W-1:0]  rad_q, rad_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [W-1:0]     root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RW-1:0]    rem_sh, trial;
  logic [W-1:0]     res_q, res_d;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q[RW-3:0], rad_q[SQ_W-1 -: 2]};
    trial  = {{(RW-W-2){1'b0}}, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SQ_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // round to nearest: remainder above root means upper half
        res_d  = (rem_d > {{(RW-W){1'b0}}, root_d}) ? root_d + 1'b1 : root_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = res_q;

endmodule

/* design/tspr_div.sv */
// iterative rounded, saturating phase divider, one quotient bit per cycle
module tspr_div
  import tspr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [W-1:0]            mag_i,
  output unit_stat_t              stat_o,
  output logic signed [W-1:0]     quot_o
);

  logic [W-1:0]     mag_q, mag_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     num_q, num_d;
  logic [W-1:0]     q_q, q_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             neg_q, neg_d, sat_q, sat_d;
  logic             neg_in;
  logic [SUM_W-1:0] abs_in;
  logic [NUM_W-1:0] num_in;
  logic [W:0]       rem_sh;

  // rounded numerator and early saturation check at start
  always_comb begin
    neg_in = sum_i[SUM_W-1];
    abs_in = neg_in ? (-sum_i) : sum_i;
    num_in = abs_in[NUM_W-1:0] + NUM_W'(mag_i >> 1);
  end

  always_comb begin
    rem_sh = {rem_q, num_q[W-1]};
    mag_d  = mag_q;
    rem_d  = rem_q;
    num_d  = num_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    sat_d  = sat_q;
    if (start_i) begin
      mag_d = mag_i;
      neg_d = neg_in;
      sat_d = (num_in >= {1'b0, mag_i, {W{1'b0}}});
      rem_d = num_in[NUM_W-2 -: W];
      num_d = num_in[W-1:0];
      q_d   = '0;
      cnt_d = '0;
      if (sat_d) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      num_d = {num_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= {1'b0, mag_q}) begin
        rem_d = W'(rem_sh - {1'b0, mag_q});
        q_d   = {q_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[W-1:0];
        q_d   = {q_q[W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    num_q <= num_d;
    q_q   <= q_d;
    neg_q <= neg_d;
    sat_q <= sat_d;
  end

  // sign and clamp to the q1 range
  always_comb begin
    if (sat_q) begin
      quot_o = neg_q ? PH_MIN : PH_ONE;
    end else if (neg_q) begin
      quot_o = (q_q > PH_MIN) ? PH_MIN : (-$signed(q_q));
    end else begin
      quot_o = (q_q > PH_ONE) ? PH_ONE : $signed(q_q);
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

/* design/tridiag_subdiag_phase_removal_core.sv */
// top level: sequencer, shared multiplier and result register
//
// Removes the phase of the complex subdiagonal of a Hermitian tridiagonal
// matrix. Each request on the slave stream carries one entry (re, im),
// tuser marks the first entry of a matrix (stored phase restarts at one)
// and tlast marks the last. Each request yields one result on the master
// stream: the magnitude, the new unit phase (re, im) and a tuser flag set
// when the entry was zero and the phase was forced to one; tlast is copied.
// Per entry, the shared 16x16 multiplier forms six products through one
// register stage, then the square root unit runs, then the divider, which
// is used for the real and then the imaginary phase part, all under the
// sequencer. The divider ends early, without iterating, when the quotient
// saturates.
// s_axis_tready is high only while the sequencer is idle. The result sits
// in an output register, so the next request is taken while a result
// still waits; if the receiver stalls, the block holds the finished
// result of the following entry until the register frees up.
// Reset empties the output register and sets the stored phase to one.
module tridiag_subdiag_phase_removal_core
  import tspr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // elem_re, elem_im
  input  logic                   s_axis_tuser_i,   // first
  input  logic                   s_axis_tlast_i,   // last_in
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // magnitude, phase_re, phase_im
  output logic                   m_axis_tuser_o,   // zero_entry
  output logic                   m_axis_tlast_o    // last_out
);

  tspr_state_e state_q, state_d;

  logic signed [W-1:0]     are_q, aim_q, pr_q, pi_q;
  logic signed [W-1:0]     prev_re_q, prev_im_q;
  logic signed [W-1:0]     prev_re_d, prev_im_d;
  logic                    last_q;
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [W-1:0]     op_a, op_b;
  logic signed [SQ_W-1:0]  prod_q;
  logic [STEP_W-1:0]       prod_step_q;
  logic [SQ_W-1:0]         sq_q;
  logic signed [SUM_W-1:0] sre_q, sim_q;
  logic [W-1:0]            mag_q;
  logic signed [W-1:0]     nre_q, nim_q;
  logic                    zero_q;
  logic                    in_acc, out_load;
  logic                    sqrt_start, div_start;
  logic signed [SUM_W-1:0] div_sum;
  logic [W-1:0]            div_mag;
  unit_stat_t              sqrt_stat, div_stat;
  logic [W-1:0]            root;
  logic signed [W-1:0]     quot;

  logic                    out_valid_q;
  logic [W-1:0]            out_mag_q;
  logic signed [W-1:0]     out_re_q, out_im_q;
  logic                    out_zero_q, out_last_q;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer
  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    s_axis_tready_o = 1'b0;
    sqrt_start      = 1'b0;
    div_start       = 1'b0;
    div_sum         = sre_q;
    div_mag         = mag_q;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          step_d  = STEP_RE_SQ;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_END) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_stat.done) begin
          if (root == '0) begin
            state_d = ST_DONE;
          end else begin
            div_start = 1'b1;
            div_sum   = sre_q;
            div_mag   = root;
            state_d   = ST_DIV_RE;
          end
        end
      end
      ST_DIV_RE: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_sum   = sim_q;
          state_d   = ST_DIV_IM;
        end
      end
      ST_DIV_IM: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_RE_SQ;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // capture the entry and the phase it is rotated by
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      are_q  <= s_axis_tdata_i[W-1:0];
      aim_q  <= s_axis_tdata_i[2*W-1:W];
      last_q <= s_axis_tlast_i;
      pr_q   <= s_axis_tuser_i ? PH_ONE : prev_re_q;
      pi_q   <= s_axis_tuser_i ? '0 : prev_im_q;
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = are_q;
    op_b = are_q;
    case (step_q)
      STEP_RE_SQ: begin op_a = are_q; op_b = are_q; end
      STEP_IM_SQ: begin op_a = aim_q; op_b = aim_q; end
      STEP_RR:    begin op_a = are_q; op_b = pr_q;  end
      STEP_II:    begin op_a = aim_q; op_b = pi_q;  end
      STEP_RI:    begin op_a = are_q; op_b = pi_q;  end
      STEP_IR:    begin op_a = aim_q; op_b = pr_q;  end
      default:    begin op_a = are_q; op_b = are_q; end
    endcase
  end

  // registered product, then accumulate the step before
  always_ff @(posedge clk_i) begin
    prod_q      <= op_a * op_b;
    prod_step_q <= step_q;
    if (in_acc) begin
      sq_q  <= '0;
      sre_q <= '0;
      sim_q <= '0;
    end else if (state_q == ST_MAC && step_q != STEP_RE_SQ) begin
      case (prod_step_q) inside
        STEP_RE_SQ, STEP_IM_SQ: sq_q  <= sq_q + prod_q;
        STEP_RR, STEP_II:       sre_q <= sre_q + SUM_W'(prod_q);
        STEP_RI:                sim_q <= sim_q + SUM_W'(prod_q);
        STEP_IR:                sim_q <= sim_q - SUM_W'(prod_q);
        default:                sq_q  <= sq_q;
      endcase
    end
  end

  tspr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_q),
    .stat_o  (sqrt_stat),
    .root_o  (root)
  );

  tspr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (div_sum),
    .mag_i   (div_mag),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // collect unit results
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT && sqrt_stat.done) begin
      mag_q  <= root;
      zero_q <= (root == '0);
      nre_q  <= PH_ONE;
      nim_q  <= '0;
    end
    if (state_q == ST_DIV_RE && div_stat.done) begin
      nre_q <= quot;
    end
    if (state_q == ST_DIV_IM && div_stat.done) begin
      nim_q <= quot;
    end
  end

  // stored phase carries over to the next entry
  always_comb begin
    prev_re_d = prev_re_q;
    prev_im_d = prev_im_q;
    if (out_load) begin
      prev_re_d = nre_q;
      prev_im_d = nim_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_re_q   <= PH_ONE;
      prev_im_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_re_q <= prev_re_d;
      prev_im_q <= prev_im_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mag_q  <= mag_q;
      out_re_q   <= nre_q;
      out_im_q   <= nim_q;
      out_zero_q <= zero_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-3*W){1'b0}}, out_im_q, out_re_q, out_mag_q};
  assign m_axis_tuser_o  = out_zero_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* design/tspr_checker.sv */
// port-level checks for the phase removal core and their binding
module tspr_checker
  import tspr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // elem_re, elem_im
  input logic                   s_axis_tuser_i,   // first
  input logic                   s_axis_tlast_i,   // last_in
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // magnitude, phase_re, phase_im
  input logic                   m_axis_tuser_o,   // zero_entry
  input logic                   m_axis_tlast_o    // last_out
);

  // one entry at a time: busy right after a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("core took a request while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

  // zero entry gives zero magnitude and unit phase
  a_zero_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[W-1:0] == '0 && m_axis_tdata_o[2*W-1:W] == PH_ONE &&
       m_axis_tdata_o[3*W-1:2*W] == '0))
    else $error("zero entry with wrong result");

  // nonzero magnitude never flagged as zero
  a_flag_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[W-1:0] != '0) |-> !m_axis_tuser_o)
    else $error("zero flag on nonzero magnitude");

endmodule

bind tridiag_subdiag_phase_removal_core tspr_checker u_tspr_checker (.*);

/* tb/sv/tspr_checker.sv */
// result checker for the subdiagonal phase removal block
`timescale 1ns / 1ps
module tspr_scoreboard
  import tspr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // elem_re, elem_im
  input  logic                   s_axis_tuser_i,   // first
  input  logic                   s_axis_tlast_i,   // last_in
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // magnitude, phase_re, phase_im
  input  logic                   m_axis_tuser_i,   // zero_entry
  input  logic                   m_axis_tlast_i,   // last_out
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [W-1:0]        magnitude;
    logic signed [W-1:0] phase_re;
    logic signed [W-1:0] phase_im;
    logic                zero_entry;
    logic                last_out;
  } phase_result_t;

  phase_result_t       expected_q[$];
  logic signed [W-1:0] held_re, held_im;

  // rounded integer square root
  function automatic longint root_rounded(longint s);
    longint r, t;
    r = 0;
    for (int b = W; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  // divide by magnitude, round half away from zero, saturate to Q1.F
  function automatic longint scale_to_unit(longint num, longint mag);
    longint a, q;
    a = (num < 0) ? -num : num;
    q = (a + (mag >> 1)) / mag;
    if (num < 0) return (q > 2 ** (W - 1)) ? -(2 ** (W - 1)) : -q;
    return (q > 2 ** (W - 1) - 1) ? 2 ** (W - 1) - 1 : q;
  endfunction

  // new phase from entry and stored phase
  function automatic phase_result_t rotate_entry(logic signed [W-1:0] are,
                                                 logic signed [W-1:0] aim,
                                                 logic signed [W-1:0] pr,
                                                 logic signed [W-1:0] pi,
                                                 logic lst);
    phase_result_t r;
    longint        mag;
    mag = root_rounded(longint'(are) * are + longint'(aim) * aim);
    r.magnitude  = mag[W-1:0];
    r.zero_entry = (mag == 0);
    r.last_out   = lst;
    if (mag == 0) begin
      r.phase_re = PH_ONE;
      r.phase_im = '0;
    end else begin
      r.phase_re = W'(scale_to_unit(longint'(are) * pr + longint'(aim) * pi, mag));
      r.phase_im = W'(scale_to_unit(longint'(are) * pi - longint'(aim) * pr, mag));
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // predict on each accepted request, compare on each accepted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    phase_result_t e, got;
    logic signed [W-1:0] pr, pi;
    if (!rst_ni) begin
      held_re  <= PH_ONE;
      held_im  <= '0;
      errors_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pr = s_axis_tuser_i ? PH_ONE : held_re;
        pi = s_axis_tuser_i ? '0 : held_im;
        e = rotate_entry(s_axis_tdata_i[W-1:0], s_axis_tdata_i[2*W-1:W], pr, pi,
                         s_axis_tlast_i);
        held_re <= e.phase_re;
        held_im <= e.phase_im;
        expected_q.push_back(e);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.magnitude  = m_axis_tdata_i[W-1:0];
        got.phase_re   = m_axis_tdata_i[2*W-1:W];
        got.phase_im   = m_axis_tdata_i[3*W-1:2*W];
        got.zero_entry = m_axis_tuser_i;
        got.last_out   = m_axis_tlast_i;
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            errors_o <= errors_o + 1;
            if (got.magnitude !== e.magnitude)
              $error("magnitude: expected %0d, got %0d", e.magnitude, got.magnitude);
            if (got.phase_re !== e.phase_re)
              $error("phase_re: expected %0d, got %0d", e.phase_re, got.phase_re);
            if (got.phase_im !== e.phase_im)
              $error("phase_im: expected %0d, got %0d", e.phase_im, got.phase_im);
            if (got.zero_entry !== e.zero_entry)
              $error("zero_entry: expected %0b, got %0b", e.zero_entry, got.zero_entry);
            if (got.last_out !== e.last_out)
              $error("last_out: expected %0b, got %0b", e.last_out, got.last_out);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// stimulus and verdict for the subdiagonal phase removal block
`timescale 1ns / 1ps
module tb_top;
  import tspr_pkg::*;

  logic                   clk, rst_n;
  logic                   s_valid, s_ready, s_user, s_last;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   m_valid, m_ready, m_user, m_last;
  logic [OUT_TDATA_W-1:0] m_data;
  int                     errors, pending;
  int                     send_idle_pct, recv_stall_pct;
  logic                   rx_hold;
  int                     n_sent, n_matrices;

  tridiag_subdiag_phase_removal_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  tspr_scoreboard chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver with random stalls and an optional long hold
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one request, with random idle cycles in front of it
  task automatic send_entry(logic [W-1:0] re, logic [W-1:0] im, logic fst, logic lst);
    bit idle_set;
    idle_set = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!idle_set) s_valid <= 1'b0;
      idle_set = 1;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {im, re};
    s_user  <= fst;
    s_last  <= lst;
    do @(posedge clk); while (!s_ready);
    n_sent++;
  endtask

  // random entry value: full range, tiny, extremes or zero
  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(9)) inside
      0, 1:    return W'($urandom_range(6)) - W'(3);
      2:       return PH_MIN;
      3:       return PH_ONE;
      4:       return '0;
      default: return W'($urandom);
    endcase
  endfunction

  // one matrix of random length, sometimes malformed
  task automatic send_matrix();
    int  len;
    bit  zap;
    len = $urandom_range(1, 10);
    zap = ($urandom_range(9) == 0);
    n_matrices++;
    for (int k = 0; k < len; k++)
      send_entry(pick_value(), pick_value(),
                 zap ? 1'($urandom) : (k == 0),
                 zap ? 1'($urandom) : (k == len - 1));
  endtask

  // let the last request reach the checker, then wait for all results
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    s_valid = 1'b0; s_data = '0; s_user = 1'b0; s_last = 1'b0;
    rx_hold = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_sent = 0; n_matrices = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, extremes, tiny entries, chain rules
    send_entry('0, '0, 1, 0);
    send_entry(PH_MIN, PH_MIN, 0, 0);
    send_entry(PH_ONE, PH_ONE, 0, 0);
    send_entry(PH_MIN, '0, 0, 0);
    send_entry('0, PH_MIN, 0, 0);
    send_entry(PH_ONE, PH_MIN, 0, 1);
    // chain continues past last without first
    send_entry(16'd1, '0, 0, 0);
    send_entry('0, 16'd1, 0, 0);
    send_entry(16'd1, 16'd1, 0, 0);
    send_entry(16'hFFFF, 16'hFFFF, 0, 0);
    send_entry(16'd2, 16'hFFFF, 0, 1);
    send_entry('0, '0, 0, 0);
    send_entry(16'd3, 16'd1, 1, 0);
    send_entry(16'h4000, 16'hC000, 0, 0);
    send_entry(16'h5A82, 16'h5A82, 0, 0);
    send_entry(16'hAAAA, 16'h5555, 1, 1);
    send_entry(16'h5555, 16'hAAAA, 1, 1);
    send_entry(16'h7FFF, '0, 1, 0);
    send_entry(16'h8001, 16'h0001, 0, 1);
    drain();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 0) begin
        // long receiver hold while requests keep coming
        fork
          begin
            rx_hold <= 1'b1;
            repeat (500) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      while (n_sent < 19 + 110 * (ph + 1)) send_matrix();
      // sender pauses until all results are back
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d entries in %0d random matrices plus directed cases,",
             n_sent, n_matrices);
    $display("under four idle and stall patterns and one long receiver hold");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tspr_pkg.sv
design/tspr_sqrt.sv
design/tspr_div.sv
design/tridiag_subdiag_phase_removal_core.sv
design/tspr_checker.sv
tb/sv/tspr_checker.sv
tb/sv/tb_top.sv
